/* rtl/core/stop_and_wait_lossy_sender_assert.svh */
// ----------------------------------------------------------------------------
// Stop-and-wait lossy sender assertion macros
// Shared property forms for the sender checker, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef STOP_AND_WAIT_LOSSY_SENDER_ASSERT_SVH
`define STOP_AND_WAIT_LOSSY_SENDER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SWLS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swls assertion failed");

// antecedent implies consequent in the following cycle
`define SWLS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swls assertion failed");

`endif

/* rtl/core/swls_pkg.sv */
// ----------------------------------------------------------------------------
// Stop-and-wait lossy sender package
// Command and action codes, field widths and reset constants.
// ----------------------------------------------------------------------------
package swls_pkg;

    localparam int WINDOW_DEFAULT = 16;
    localparam int ACCEPT_RESET   = 10;
    localparam int PCT_SCALE      = 100;
    localparam int ACCEPT_W       = 7;
    localparam int LOSS_W         = 5;
    localparam int LOSS_MAX       = 31;

    typedef enum logic [1:0] {
        CMD_SEND    = 2'd0,
        CMD_PDU     = 2'd1,
        CMD_TIMEOUT = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ACT_TRANSMIT = 2'd0,
        ACT_DELIVERED = 2'd1,
        ACT_ABANDONED = 2'd2,
        ACT_IGNORED  = 2'd3
    } action_t;

endpackage

/* rtl/core/stop_and_wait_lossy_sender.sv */
// ----------------------------------------------------------------------------
// Stop-and-wait lossy sender
// One-bit sequence sender that drops timed-out messages while recent loss
// stays under a programmable percentage.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  cmd       cmd_valid / cmd_ready  command, is_ack, ack_number
//  res       res_valid / res_ready  action, seq_out, loss_count
//  cfg       cfg_wr_en              cfg_wr_data (accept_loss_percent)
//
//  One word per cycle while cmd_ready is high: each event is decoded and state
//  updated in the cycle it is accepted; its result is registered for res.
//  A two-entry output (result register plus skid register) keeps cmd_ready
//  registered; cmd_ready drops only while both entries hold words.
//  Reset: nothing in flight, expected ack 0, loss window empty, threshold 10%.
// ----------------------------------------------------------------------------
module stop_and_wait_lossy_sender #(
    parameter int WINDOW = swls_pkg::WINDOW_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [swls_pkg::ACCEPT_W-1:0] cfg_wr_data,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  logic [1:0]                    command,
    input  logic                          is_ack,
    input  logic                          ack_number,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [1:0]                    action,
    output logic                          seq_out,
    output logic [swls_pkg::LOSS_W-1:0]   loss_count
);

    localparam int CntW  = $clog2(WINDOW + 1);
    localparam int ProdW = $clog2(WINDOW) + swls_pkg::ACCEPT_W + 1;
    localparam int SatW  = (CntW > swls_pkg::LOSS_W) ? CntW : swls_pkg::LOSS_W;

    // state
    logic                 expected_ack_reg, expected_ack_next;
    logic                 in_flight_reg, in_flight_next;
    logic [WINDOW-1:0]    window_reg, window_next;
    logic [CntW-1:0]      count_reg, count_next;
    logic [ProdW-1:0]     thresh_reg;

    // output stage
    logic                 out_valid_reg, skid_valid_reg;
    swls_pkg::action_t    out_action_reg, skid_action_reg;
    logic                 out_seq_reg, skid_seq_reg;
    logic [swls_pkg::LOSS_W-1:0] out_loss_reg, skid_loss_reg;

    // decode
    logic                 accept;
    swls_pkg::action_t    act;
    logic                 seq;
    logic                 rec, rec_bit;
    logic                 old_bit;
    logic [CntW-1:0]      count_tmo;
    logic                 abandon;
    logic [SatW-1:0]      count_wide;
    logic [swls_pkg::LOSS_W-1:0] loss_sat;

    assign cmd_ready = !skid_valid_reg;
    assign accept    = cmd_valid && cmd_ready;

    // oldest outcome leaves the window when a new one is recorded
    assign old_bit   = window_reg[WINDOW-1];
    assign count_tmo = CntW'(count_reg + CntW'(1) - CntW'(old_bit));
    // floor(L*100/W) < A  <=>  L*100 < A*W
    assign abandon   = (ProdW'(count_tmo) * ProdW'(swls_pkg::PCT_SCALE)) < thresh_reg;

    always_comb
    begin
        act               = swls_pkg::ACT_IGNORED;
        seq               = 1'b0;
        rec               = 1'b0;
        rec_bit           = 1'b0;
        expected_ack_next = expected_ack_reg;
        in_flight_next    = in_flight_reg;
        case (command)
            swls_pkg::CMD_SEND:
            begin
                if (!in_flight_reg)
                begin
                    act               = swls_pkg::ACT_TRANSMIT;
                    seq               = expected_ack_reg;
                    expected_ack_next = !expected_ack_reg;
                    in_flight_next    = 1'b1;
                end
            end
            swls_pkg::CMD_PDU:
            begin
                if (in_flight_reg)
                begin
                    if (is_ack && (ack_number == expected_ack_reg))
                    begin
                        act            = swls_pkg::ACT_DELIVERED;
                        rec            = 1'b1;
                        in_flight_next = 1'b0;
                    end
                    else
                    begin
                        // wrong ack counts as a loss, plain pdu records nothing
                        act     = swls_pkg::ACT_TRANSMIT;
                        seq     = !expected_ack_reg;
                        rec     = is_ack;
                        rec_bit = 1'b1;
                    end
                end
            end
            swls_pkg::CMD_TIMEOUT:
            begin
                if (in_flight_reg)
                begin
                    rec     = 1'b1;
                    rec_bit = 1'b1;
                    if (abandon)
                    begin
                        act               = swls_pkg::ACT_ABANDONED;
                        expected_ack_next = !expected_ack_reg;
                        in_flight_next    = 1'b0;
                    end
                    else
                    begin
                        act = swls_pkg::ACT_TRANSMIT;
                        seq = !expected_ack_reg;
                    end
                end
            end
            default:
            begin
                act = swls_pkg::ACT_IGNORED;
            end
        endcase
    end

    always_comb
    begin
        window_next = window_reg;
        count_next  = count_reg;
        if (rec)
        begin
            window_next = (window_reg << 1) | WINDOW'(rec_bit);
            count_next  = CntW'(count_reg + CntW'(rec_bit) - CntW'(old_bit));
        end
    end

    assign count_wide = SatW'(count_next);
    assign loss_sat   = (count_wide > SatW'(swls_pkg::LOSS_MAX)) ?
                        swls_pkg::LOSS_W'(swls_pkg::LOSS_MAX) :
                        count_wide[swls_pkg::LOSS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_ack_reg <= 1'b0;
            in_flight_reg    <= 1'b0;
            window_reg       <= '0;
            count_reg        <= '0;
            thresh_reg       <= ProdW'(swls_pkg::ACCEPT_RESET * WINDOW);
        end
        else
        begin
            if (cfg_wr_en)
            begin
                thresh_reg <= ProdW'(cfg_wr_data) * ProdW'(WINDOW);
            end
            if (accept)
            begin
                expected_ack_reg <= expected_ack_next;
                in_flight_reg    <= in_flight_next;
                window_reg       <= window_next;
                count_reg        <= count_next;
            end
        end
    end

    // output register with skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || res_ready)
            begin
                out_valid_reg  <= skid_valid_reg || accept;
                skid_valid_reg <= 1'b0;
            end
            else if (accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || res_ready)
        begin
            if (skid_valid_reg)
            begin
                out_action_reg <= skid_action_reg;
                out_seq_reg    <= skid_seq_reg;
                out_loss_reg   <= skid_loss_reg;
            end
            else if (accept)
            begin
                out_action_reg <= act;
                out_seq_reg    <= seq;
                out_loss_reg   <= loss_sat;
            end
        end
        else if (accept)
        begin
            // hold the waiting word, park the new one
            skid_action_reg <= act;
            skid_seq_reg    <= seq;
            skid_loss_reg   <= loss_sat;
        end
    end

    assign res_valid  = out_valid_reg;
    assign action     = out_action_reg;
    assign seq_out    = out_seq_reg;
    assign loss_count = out_loss_reg;

endmodule

/* rtl/core/swls_checker.sv */
// ----------------------------------------------------------------------------
// Stop-and-wait lossy sender checker
// Port-level checks on result words and backpressure, bound to the top level.
// ----------------------------------------------------------------------------
`include "stop_and_wait_lossy_sender_assert.svh"

module swls_checker #(
    parameter int WINDOW = swls_pkg::WINDOW_DEFAULT
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cmd_ready,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic [1:0]                  action,
    input logic                        seq_out,
    input logic [swls_pkg::LOSS_W-1:0] loss_count
);

    localparam int LossLimit = (WINDOW < swls_pkg::LOSS_MAX) ? WINDOW : swls_pkg::LOSS_MAX;

    logic [swls_pkg::LOSS_W+2:0] res_word;

    assign res_word = {action, seq_out, loss_count};

    // sequence bit carries meaning only on a transmit
    `SWLS_ASSERT_NOW(a_seq_zero, res_valid && (action != swls_pkg::ACT_TRANSMIT), !seq_out)

    // loss count never exceeds the window
    `SWLS_ASSERT_NOW(a_loss_bound, res_valid, loss_count <= swls_pkg::LOSS_W'(LossLimit))

    // backpressure only while a word is waiting on res
    `SWLS_ASSERT_NOW(a_ready_blocks, !cmd_ready, res_valid)

    // a stalled result word holds
    `SWLS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_word))

endmodule

bind stop_and_wait_lossy_sender swls_checker #(
    .WINDOW(WINDOW)
) u_swls_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_ready  (cmd_ready),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .action     (action),
    .seq_out    (seq_out),
    .loss_count (loss_count)
);
